// ===== rtl/core/fpes_pkg.sv =====
`default_nettype none

package fpes_pkg;

	// page size of one bank window
	localparam int PAGE_BITS = 14;

	localparam int ADDR_W = 20;
	localparam int WAIT_W = 10;
	localparam int STEP_N = 15;
	localparam int STEP_W = 4;

	localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'((1 << PAGE_BITS) - 1);
	localparam logic [ADDR_W-1:0] SECTOR_MASK = ~ADDR_W'(20'hFFF);
	localparam logic [5:0] PAGE_ONE = 6'(((1 << PAGE_BITS) >> PAGE_BITS));

	// bus command constants
	localparam logic [15:0] UNLOCK_A1 = 16'h5555;
	localparam logic [15:0] UNLOCK_A2 = 16'h2AAA;
	localparam logic [15:0] WINDOW_BASE = 16'h8000;
	localparam logic [7:0] UNLOCK_D1 = 8'hAA;
	localparam logic [7:0] UNLOCK_D2 = 8'h55;
	localparam logic [7:0] CMD_PROGRAM = 8'hA0;
	localparam logic [7:0] CMD_ERASE = 8'h80;
	localparam logic [7:0] CMD_CHIP = 8'h10;
	localparam logic [7:0] CMD_SECTOR = 8'h30;

	// result kinds
	localparam logic [2:0] K_BANK = 3'd0;
	localparam logic [2:0] K_WRITE = 3'd1;
	localparam logic [2:0] K_WAIT = 3'd2;
	localparam logic [2:0] K_ACQ = 3'd3;
	localparam logic [2:0] K_REL = 3'd4;
	localparam logic [2:0] K_REFUSE = 3'd5;

	// request kinds on the input
	localparam logic REQ_PROGRAM = 1'b0;
	localparam logic REQ_ERASE = 1'b1;

	// operation classes between front and back
	localparam logic [1:0] OP_REFUSE = 2'd0;
	localparam logic [1:0] OP_PROG = 2'd1;
	localparam logic [1:0] OP_ERASE = 2'd2;

	// configuration register indexes
	localparam logic CFG_PROG_WAIT = 1'b0;
	localparam logic CFG_ERASE_WAIT = 1'b1;

	// program sequence steps
	localparam logic [STEP_W-1:0] PS_BANK0 = 4'd0;
	localparam logic [STEP_W-1:0] PS_BANK1 = 4'd1;
	localparam logic [STEP_W-1:0] PS_BANK2 = 4'd2;
	localparam logic [STEP_W-1:0] PS_ACQ = 4'd3;
	localparam logic [STEP_W-1:0] PS_UNL1 = 4'd4;
	localparam logic [STEP_W-1:0] PS_UNL2 = 4'd5;
	localparam logic [STEP_W-1:0] PS_CMD = 4'd6;
	localparam logic [STEP_W-1:0] PS_PG_REL = 4'd7;
	localparam logic [STEP_W-1:0] PS_PG_BANK = 4'd8;
	localparam logic [STEP_W-1:0] PS_PG_ACQ = 4'd9;
	localparam logic [STEP_W-1:0] PS_DATA = 4'd10;
	localparam logic [STEP_W-1:0] PS_WAIT = 4'd11;
	localparam logic [STEP_W-1:0] PS_REL = 4'd12;

	// erase sequence steps
	localparam logic [STEP_W-1:0] ES_BANK0 = 4'd0;
	localparam logic [STEP_W-1:0] ES_BANK1 = 4'd1;
	localparam logic [STEP_W-1:0] ES_ACQ = 4'd2;
	localparam logic [STEP_W-1:0] ES_UNL1 = 4'd3;
	localparam logic [STEP_W-1:0] ES_UNL2 = 4'd4;
	localparam logic [STEP_W-1:0] ES_CMD = 4'd5;
	localparam logic [STEP_W-1:0] ES_UNL3 = 4'd6;
	localparam logic [STEP_W-1:0] ES_UNL4 = 4'd7;
	localparam logic [STEP_W-1:0] ES_CHIP = 4'd8;
	localparam logic [STEP_W-1:0] ES_SEC_REL = 4'd9;
	localparam logic [STEP_W-1:0] ES_SEC_BANK = 4'd10;
	localparam logic [STEP_W-1:0] ES_SEC_ACQ = 4'd11;
	localparam logic [STEP_W-1:0] ES_SECTOR = 4'd12;
	localparam logic [STEP_W-1:0] ES_WAIT = 4'd13;
	localparam logic [STEP_W-1:0] ES_REL = 4'd14;

	typedef struct packed {
		logic req_type;
		logic [ADDR_W-1:0] address;
		logic [7:0] data_byte;
		logic first_byte;
		logic last_byte;
		logic bus_held;
	} fpes_in_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [1:0] bank_slot;
		logic [5:0] bank_page;
		logic [15:0] bus_address;
		logic [7:0] bus_data;
		logic [WAIT_W-1:0] wait_amount;
		logic wait_in_ms;
		logic end_of_run;
	} fpes_out_t;

	// classified request handed from front to back
	typedef struct packed {
		logic [1:0] op;
		logic [STEP_N-1:0] steps;
		logic [ADDR_W-1:0] addr;
		logic [7:0] data;
	} fpes_desc_t;

	// index of the lowest pending step
	function automatic logic [STEP_W-1:0] first_step(input logic [STEP_N-1:0] m);
		logic [STEP_W-1:0] idx;
		idx = '0;
		for (int i = STEP_N - 1; i >= 0; i--) begin
			if (m[i]) begin
				idx = STEP_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fpes_front.sv =====
`default_nettype none

module fpes_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire fpes_pkg::fpes_in_t in_word,
	output logic push_valid,
	input wire logic push_ready,
	output fpes_pkg::fpes_desc_t push_desc
);
	import fpes_pkg::*;

	logic run_open_q;
	logic [ADDR_W-1:0] next_address_q;
	logic accept;
	logic [ADDR_W-1:0] eff_addr;
	logic page_start;
	logic start_ok;
	fpes_desc_t desc;

	assign in_ready = push_ready;
	assign push_valid = in_valid;
	assign accept = in_valid && push_ready;

	// address of the byte and whether it opens a page
	assign eff_addr = in_word.first_byte ? in_word.address : next_address_q;
	assign page_start = (eff_addr & PAGE_MASK) == '0;
	assign start_ok = run_open_q || !in_word.bus_held;

	// classify the request into an op and a step mask
	always_comb begin
		desc = '0;
		desc.addr = eff_addr;
		desc.data = in_word.data_byte;
		desc.op = OP_REFUSE;
		desc.steps[PS_BANK0] = 1'b1;
		if (in_word.req_type == REQ_ERASE) begin
			if (!run_open_q && !in_word.bus_held) begin
				desc.op = OP_ERASE;
				desc.addr = in_word.address;
				desc.steps = '1;
				if (in_word.address[ADDR_W-1]) begin
					desc.steps[ES_SEC_REL] = 1'b0;
					desc.steps[ES_SEC_BANK] = 1'b0;
					desc.steps[ES_SEC_ACQ] = 1'b0;
					desc.steps[ES_SECTOR] = 1'b0;
				end else begin
					desc.steps[ES_CHIP] = 1'b0;
				end
			end
		end else if ((in_word.first_byte && start_ok) ||
				(!in_word.first_byte && run_open_q)) begin
			desc.op = OP_PROG;
			desc.steps = '0;
			desc.steps[PS_BANK0] = in_word.first_byte;
			desc.steps[PS_BANK1] = in_word.first_byte;
			desc.steps[PS_BANK2] = in_word.first_byte;
			desc.steps[PS_ACQ] = in_word.first_byte && !run_open_q;
			desc.steps[PS_UNL1] = 1'b1;
			desc.steps[PS_UNL2] = 1'b1;
			desc.steps[PS_CMD] = 1'b1;
			desc.steps[PS_PG_REL] = page_start;
			desc.steps[PS_PG_BANK] = page_start;
			desc.steps[PS_PG_ACQ] = page_start;
			desc.steps[PS_DATA] = 1'b1;
			desc.steps[PS_WAIT] = 1'b1;
			desc.steps[PS_REL] = in_word.last_byte;
		end
	end

	assign push_desc = desc;

	// run state follows each accepted program word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_open_q <= 1'b0;
			next_address_q <= '0;
		end else if (accept && desc.op == OP_PROG) begin
			run_open_q <= !in_word.last_byte;
			next_address_q <= eff_addr + ADDR_W'(1);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/fpes_queue.sv =====
`default_nettype none

module fpes_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push_valid,
	output logic push_ready,
	input wire fpes_pkg::fpes_desc_t push_desc,
	output logic pop_valid,
	input wire logic pop_ready,
	output fpes_pkg::fpes_desc_t pop_desc
);
	import fpes_pkg::*;

	fpes_desc_t ent_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic push;
	logic pop;

	assign push_ready = count_q != 2'd2;
	assign pop_valid = count_q != 2'd0;
	assign pop_desc = ent_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_desc;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/fpes_back.sv =====
`default_nettype none

module fpes_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic pop_valid,
	output logic pop_ready,
	input wire fpes_pkg::fpes_desc_t pop_desc,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [fpes_pkg::WAIT_W-1:0] cfg_wdata,
	output logic out_valid,
	input wire logic out_ready,
	output fpes_pkg::fpes_out_t out_word
);
	import fpes_pkg::*;

	logic busy_q;
	fpes_desc_t cur_q;
	logic [WAIT_W-1:0] prog_wait_q;
	logic [WAIT_W-1:0] erase_wait_q;
	logic out_valid_q;
	fpes_out_t out_word_q;

	logic advance;
	logic fire;
	logic [STEP_W-1:0] step;
	logic [STEP_N-1:0] rest;
	logic done;
	fpes_out_t item;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_wait_q <= WAIT_W'(20);
			erase_wait_q <= WAIT_W'(100);
		end else if (cfg_we) begin
			if (cfg_index == CFG_PROG_WAIT) begin
				prog_wait_q <= cfg_wdata;
			end else begin
				erase_wait_q <= cfg_wdata;
			end
		end
	end

	// pick the next pending step
	assign step = first_step(cur_q.steps);
	assign rest = cur_q.steps & (cur_q.steps - STEP_N'(1));
	assign done = rest == '0;
	assign advance = !out_valid_q || out_ready;
	assign fire = busy_q && advance;
	assign pop_ready = !busy_q || (fire && done);

	// build the word for the current step
	always_comb begin
		item = '0;
		item.end_of_run = done;
		case (cur_q.op)
			OP_PROG: begin
				case (step)
					PS_BANK0: begin
						item.kind = K_BANK;
					end
					PS_BANK1: begin
						item.kind = K_BANK;
						item.bank_slot = 2'd1;
						item.bank_page = PAGE_ONE;
					end
					PS_BANK2, PS_PG_BANK: begin
						item.kind = K_BANK;
						item.bank_slot = 2'd2;
						item.bank_page = 6'(cur_q.addr >> PAGE_BITS);
					end
					PS_ACQ, PS_PG_ACQ: begin
						item.kind = K_ACQ;
					end
					PS_UNL1: begin
						item.kind = K_WRITE;
						item.bus_address = UNLOCK_A1;
						item.bus_data = UNLOCK_D1;
					end
					PS_UNL2: begin
						item.kind = K_WRITE;
						item.bus_address = UNLOCK_A2;
						item.bus_data = UNLOCK_D2;
					end
					PS_CMD: begin
						item.kind = K_WRITE;
						item.bus_address = UNLOCK_A1;
						item.bus_data = CMD_PROGRAM;
					end
					PS_PG_REL, PS_REL: begin
						item.kind = K_REL;
					end
					PS_DATA: begin
						item.kind = K_WRITE;
						item.bus_address = 16'(cur_q.addr & PAGE_MASK) + WINDOW_BASE;
						item.bus_data = cur_q.data;
					end
					PS_WAIT: begin
						item.kind = K_WAIT;
						item.wait_amount = prog_wait_q;
					end
					default: begin
						item.kind = K_REFUSE;
					end
				endcase
			end
			OP_ERASE: begin
				case (step)
					ES_BANK0: begin
						item.kind = K_BANK;
					end
					ES_BANK1: begin
						item.kind = K_BANK;
						item.bank_slot = 2'd1;
						item.bank_page = PAGE_ONE;
					end
					ES_ACQ, ES_SEC_ACQ: begin
						item.kind = K_ACQ;
					end
					ES_UNL1, ES_UNL3: begin
						item.kind = K_WRITE;
						item.bus_address = UNLOCK_A1;
						item.bus_data = UNLOCK_D1;
					end
					ES_UNL2, ES_UNL4: begin
						item.kind = K_WRITE;
						item.bus_address = UNLOCK_A2;
						item.bus_data = UNLOCK_D2;
					end
					ES_CMD: begin
						item.kind = K_WRITE;
						item.bus_address = UNLOCK_A1;
						item.bus_data = CMD_ERASE;
					end
					ES_CHIP: begin
						item.kind = K_WRITE;
						item.bus_address = UNLOCK_A1;
						item.bus_data = CMD_CHIP;
					end
					ES_SEC_REL, ES_REL: begin
						item.kind = K_REL;
					end
					ES_SEC_BANK: begin
						item.kind = K_BANK;
						item.bank_page = 6'(cur_q.addr >> PAGE_BITS);
					end
					ES_SECTOR: begin
						item.kind = K_WRITE;
						item.bus_address = 16'(cur_q.addr & PAGE_MASK & SECTOR_MASK);
						item.bus_data = CMD_SECTOR;
					end
					ES_WAIT: begin
						item.kind = K_WAIT;
						item.wait_amount = erase_wait_q;
						item.wait_in_ms = 1'b1;
					end
					default: begin
						item.kind = K_REFUSE;
					end
				endcase
			end
			default: begin
				item.kind = K_REFUSE;
			end
		endcase
	end

	// current request and its remaining steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (pop_ready) begin
			busy_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			cur_q <= pop_desc;
		end else if (fire) begin
			cur_q.steps <= rest;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_word_q <= item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word = out_word_q;

endmodule

`default_nettype wire

// ===== rtl/core/flash_program_erase_sequencer.sv =====
`default_nettype none

// channel   signals                         direction
// in        in_valid/in_ready/in_word       request word in
// out       out_valid/out_ready/out_word    bus sequence word out
// cfg       cfg_we/cfg_index/cfg_wdata      wait register write
//
// each request gives 1 to 14 output words, one per cycle unless the output
// stalls, per the front step mask; the back pops on a request's last word
// a two-entry queue lets the front take new requests while the back works
// reset clears the run state, the queue and the output register
// a stalled output holds the sequencer; the front stalls only on a full queue

module flash_program_erase_sequencer (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire fpes_pkg::fpes_in_t in_word,
	output logic out_valid,
	input wire logic out_ready,
	output fpes_pkg::fpes_out_t out_word,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [fpes_pkg::WAIT_W-1:0] cfg_wdata
);
	import fpes_pkg::*;

	logic push_valid;
	logic push_ready;
	fpes_desc_t push_desc;
	logic pop_valid;
	logic pop_ready;
	fpes_desc_t pop_desc;

	// request classification and run state
	fpes_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_desc(push_desc)
	);

	// decoupling queue
	fpes_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_desc(push_desc),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_desc(pop_desc)
	);

	// bus sequence generator
	fpes_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_desc(pop_desc),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word)
	);

endmodule

`default_nettype wire
